// ===== rtl/core/svpd_pkg.sv =====
`default_nettype none

package svpd_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;
    localparam int SQRT_STEPS        = 16;

    // datapath width of the CORDIC x/y registers and of the sine CORDIC z registers
    localparam int CW = 34;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [15:0] PERIOD_RST = 16'd1600;
    localparam logic [15:0] GAIN_RST   = 16'd5851;
    localparam logic [15:0] LIMIT_RST  = 16'd37814;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;

    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_SIXTH   = 32'd715827883;

    localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic [30:0]          SQRT3_Q30 = 31'd1859775393;

    localparam logic [31:0] ATAN_TURN [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // first turn fraction of each sector: ceil(k * 2^32 / 6)
    localparam logic [31:0] SECTOR_BASE [6] = '{
        32'd0, 32'd715827883, 32'd1431655766, 32'd2147483648, 32'd2863311531, 32'd3579139414
    };

    typedef struct packed {
        logic                   d_zero;
        logic signed [15:0]     q;
        logic [15:0]            ang;
        logic [31:0]            sumsq;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic [31:0]            cz;
    } front_item_t;

    typedef struct packed {
        logic signed [25:0]     u_raw;
        logic [31:0]            theta;
    } polar_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/svpd_in_if.sv =====
`default_nettype none

interface svpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_voltage;
    logic signed [15:0] d_voltage;
    logic [15:0]        elec_angle;

    modport source (output valid, output q_voltage, output d_voltage, output elec_angle,
                    input ready);
    modport sink (input valid, input q_voltage, input d_voltage, input elec_angle,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/svpd_out_if.sv =====
`default_nettype none

interface svpd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic [2:0]  sector_number;

    modport source (output valid, output compare_a, output compare_b, output compare_c,
                    output sector_number, input ready);
    modport sink (input valid, input compare_a, input compare_b, input compare_c,
                  input sector_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/svpd_front.sv =====
`default_nettype none

module svpd_front (
    input  wire                    clk,
    input  wire                    rst_n,
    svpd_in_if.sink                vec,
    input  wire                    q_full,
    output logic                   push,
    output svpd_pkg::front_item_t  item
);

    logic                  vld_reg;
    svpd_pkg::front_item_t item_reg;
    svpd_pkg::front_item_t item_next;

    logic signed [15:0]             d;
    logic signed [15:0]             q;
    logic signed [31:0]             dd;
    logic signed [31:0]             qq;
    logic signed [svpd_pkg::CW-1:0] dx;
    logic signed [svpd_pkg::CW-1:0] qy;

    assign vec.ready = !vld_reg || !q_full;
    assign push      = vld_reg && !q_full;
    assign item      = item_reg;

    always_comb
    begin
        d  = vec.d_voltage;
        q  = vec.q_voltage;
        dd = d * d;
        qq = q * q;
        dx = {{(svpd_pkg::CW - 30){d[15]}}, d, 14'd0};
        qy = {{(svpd_pkg::CW - 30){q[15]}}, q, 14'd0};
        item_next.d_zero = (d == 16'sd0);
        item_next.q      = q;
        item_next.ang    = vec.elec_angle;
        item_next.sumsq  = $unsigned(dd) + $unsigned(qq);
        // fold the left half plane onto the right before vectoring
        if (d[15])
        begin
            item_next.cx = -dx;
            item_next.cy = -qy;
            item_next.cz = svpd_pkg::TURN_HALF;
        end
        else
        begin
            item_next.cx = dx;
            item_next.cy = qy;
            item_next.cz = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (vec.ready)
            vld_reg <= vec.valid;
    end

    always_ff @(posedge clk)
    begin
        if (vec.valid && vec.ready)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/svpd_queue.sv =====
`default_nettype none

module svpd_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire svpd_pkg::front_item_t in_item,
    input  wire                    pop,
    output svpd_pkg::front_item_t  out_item,
    output svpd_pkg::q_status_t    status
);

    svpd_pkg::front_item_t              mem [svpd_pkg::QUEUE_DEPTH];
    logic [svpd_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [svpd_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [svpd_pkg::QPTR_W:0]          cnt_reg;
    logic [svpd_pkg::QPTR_W:0]          cnt_next;

    assign out_item     = mem[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == (svpd_pkg::QPTR_W + 1)'(svpd_pkg::QUEUE_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

// ===== rtl/core/svpd_polar.sv =====
`default_nettype none

module svpd_polar #(
    parameter int ANGLE_BITS    = svpd_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = svpd_pkg::CORDIC_STAGES_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        en,
    input  wire                        in_valid,
    input  wire svpd_pkg::front_item_t in_item,
    input  wire [15:0]                 gain,
    output logic                       out_valid,
    output svpd_pkg::polar_item_t      out_item
);

    localparam int CW    = svpd_pkg::CW;
    localparam int DEPTH = (CORDIC_STAGES > svpd_pkg::SQRT_STEPS) ?
                           CORDIC_STAGES : svpd_pkg::SQRT_STEPS;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic                 vld_reg  [0:DEPTH];
    logic                 dz_reg   [0:DEPTH];
    logic signed [15:0]   q_reg    [0:DEPTH];
    logic [15:0]          ang_reg  [0:DEPTH];
    logic [31:0]          rem_reg  [0:DEPTH];
    logic [31:0]          root_reg [0:DEPTH];
    logic signed [CW-1:0] x_reg    [0:DEPTH];
    logic signed [CW-1:0] y_reg    [0:DEPTH];
    logic [31:0]          z_reg    [0:DEPTH];

    logic                  out_valid_reg;
    svpd_pkg::polar_item_t out_item_reg;
    svpd_pkg::polar_item_t out_item_next;

    logic signed [16:0] mul_a;
    logic signed [33:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_reg[0]   <= in_item.d_zero;
            q_reg[0]    <= in_item.q;
            ang_reg[0]  <= in_item.ang;
            rem_reg[0]  <= in_item.sumsq;
            root_reg[0] <= 32'd0;
            x_reg[0]    <= in_item.cx;
            y_reg[0]    <= in_item.cy;
            z_reg[0]    <= in_item.cz;
        end
    end

    // square root and vectoring CORDIC side by side, one step per stage
    for (genvar s = 1; s <= DEPTH; s++)
    begin : g_step
        localparam int I = s - 1;
        logic [31:0]          rem_n;
        logic [31:0]          root_n;
        logic signed [CW-1:0] x_n;
        logic signed [CW-1:0] y_n;
        logic [31:0]          z_n;

        if (I < svpd_pkg::SQRT_STEPS)
        begin : g_sqrt
            localparam logic [31:0] SQ_BIT = 32'd1 << (30 - 2 * I);
            logic [31:0] trial;
            always_comb
            begin
                trial = root_reg[s-1] + SQ_BIT;
                if (rem_reg[s-1] >= trial)
                begin
                    rem_n  = rem_reg[s-1] - trial;
                    root_n = (root_reg[s-1] >> 1) + SQ_BIT;
                end
                else
                begin
                    rem_n  = rem_reg[s-1];
                    root_n = root_reg[s-1] >> 1;
                end
            end
        end
        else
        begin : g_sqrt_hold
            assign rem_n  = rem_reg[s-1];
            assign root_n = root_reg[s-1];
        end

        if (I < CORDIC_STAGES)
        begin : g_rot
            localparam logic [31:0] ATAN = svpd_pkg::ATAN_TURN[I];
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            always_comb
            begin
                xs = x_reg[s-1] >>> I;
                ys = y_reg[s-1] >>> I;
                if (!y_reg[s-1][CW-1] && (y_reg[s-1] != '0))
                begin
                    x_n = x_reg[s-1] + ys;
                    y_n = y_reg[s-1] - xs;
                    z_n = z_reg[s-1] + ATAN;
                end
                else
                begin
                    x_n = x_reg[s-1] - ys;
                    y_n = y_reg[s-1] + xs;
                    z_n = z_reg[s-1] - ATAN;
                end
            end
        end
        else
        begin : g_rot_hold
            assign x_n = x_reg[s-1];
            assign y_n = y_reg[s-1];
            assign z_n = z_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dz_reg[s]   <= dz_reg[s-1];
                q_reg[s]    <= q_reg[s-1];
                ang_reg[s]  <= ang_reg[s-1];
                rem_reg[s]  <= rem_n;
                root_reg[s] <= root_n;
                x_reg[s]    <= x_n;
                y_reg[s]    <= y_n;
                z_reg[s]    <= z_n;
            end
        end
    end

    // scale by the supply gain and rotate the angle
    always_comb
    begin
        if (dz_reg[DEPTH])
            mul_a = {q_reg[DEPTH][15], q_reg[DEPTH]};
        else
            mul_a = {1'b0, root_reg[DEPTH][15:0]};
        prod = mul_a * $signed({1'b0, gain});
        out_item_next.u_raw = prod[33:8];
        if (dz_reg[DEPTH])
            out_item_next.theta = ({ang_reg[DEPTH], 16'd0} + svpd_pkg::TURN_QUARTER)
                                  & ANGLE_MASK;
        else
            out_item_next.theta = ({ang_reg[DEPTH], 16'd0} + z_reg[DEPTH]) & ANGLE_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[DEPTH];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/svpd_duty.sv =====
`default_nettype none

module svpd_duty #(
    parameter int CORDIC_STAGES = svpd_pkg::CORDIC_STAGES_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  wire svpd_pkg::polar_item_t in_item,
    input  wire [15:0]                 period,
    input  wire [15:0]                 limit,
    output logic                       en,
    svpd_out_if.source                 pwm
);

    localparam int CW = svpd_pkg::CW;
    localparam int N  = CORDIC_STAGES;
    localparam logic signed [CW-1:0] Y_MAX = CW'(1) << 30;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rot_t;

    function automatic rot_t rot_step(rot_t cur, int unsigned i, logic [31:0] atan);
        rot_t                 nxt;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] at;
        xs = cur.x >>> i;
        ys = cur.y >>> i;
        at = {2'b00, atan};
        if (!cur.z[CW-1])
        begin
            nxt.x = cur.x - ys;
            nxt.y = cur.y + xs;
            nxt.z = cur.z - at;
        end
        else
        begin
            nxt.x = cur.x + ys;
            nxt.y = cur.y - xs;
            nxt.z = cur.z + at;
        end
        return nxt;
    endfunction

    function automatic logic [30:0] clamp_sin(logic signed [CW-1:0] y);
        logic [30:0] r;
        if (y[CW-1])
            r = 31'd0;
        else if (y > Y_MAX)
            r = 31'h4000_0000;
        else
            r = y[30:0];
        return r;
    endfunction

    function automatic logic [15:0] to_compare(logic signed [21:0] duty, logic [15:0] per);
        logic signed [38:0] p;
        logic signed [22:0] c;
        logic [15:0]        r;
        p = duty * $signed({1'b0, per});
        c = p[38:16];
        if (c[22])
            r = 16'd0;
        else if (c > $signed({7'd0, per}))
            r = per;
        else
            r = c[15:0];
        return r;
    endfunction

    // stage B: clamp, sector search
    logic signed [17:0] neg_lim;
    logic signed [17:0] u_b;
    logic [2:0]         k_b;
    logic [31:0]        phi_b;

    logic               vld_reg [0:N];
    logic signed [17:0] u_reg   [0:N];
    logic [2:0]         k_reg   [0:N];
    rot_t               r1_reg  [0:N];
    rot_t               r2_reg  [0:N];

    logic               vc_reg;
    logic signed [17:0] uc_reg;
    logic [2:0]         kc_reg;
    logic [30:0]        s1c_reg;
    logic [30:0]        s2c_reg;
    logic [61:0]        p1;
    logic [61:0]        p2;

    logic               vd_reg;
    logic [2:0]         kd_reg;
    logic signed [19:0] t1d_reg;
    logic signed [19:0] t2d_reg;
    logic signed [49:0] m1;
    logic signed [49:0] m2;

    logic               ve_reg;
    logic [2:0]         ke_reg;
    logic signed [21:0] da_reg;
    logic signed [21:0] db_reg;
    logic signed [21:0] dc_reg;
    logic signed [21:0] t1e;
    logic signed [21:0] t2e;
    logic signed [21:0] he;
    logic signed [21:0] da_next;
    logic signed [21:0] db_next;
    logic signed [21:0] dc_next;

    logic               vf_reg;
    logic [15:0]        ca_reg;
    logic [15:0]        cb_reg;
    logic [15:0]        cc_reg;
    logic [2:0]         sect_reg;

    assign en = !vf_reg || pwm.ready;

    always_comb
    begin
        neg_lim = -$signed({2'b00, limit});
        if (in_item.u_raw > $signed({1'b0, limit}))
            u_b = $signed({2'b00, limit});
        else if (in_item.u_raw < neg_lim)
            u_b = neg_lim;
        else
            u_b = in_item.u_raw[17:0];
        k_b = 3'd0;
        for (int j = 1; j < 6; j++)
        begin
            if (in_item.theta >= svpd_pkg::SECTOR_BASE[j])
                k_b = 3'(j);
        end
        phi_b = in_item.theta - svpd_pkg::SECTOR_BASE[k_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0]    <= u_b;
            k_reg[0]    <= k_b;
            r1_reg[0].x <= svpd_pkg::CORDIC_K;
            r1_reg[0].y <= '0;
            r1_reg[0].z <= {2'b00, svpd_pkg::TURN_SIXTH - phi_b};
            r2_reg[0].x <= svpd_pkg::CORDIC_K;
            r2_reg[0].y <= '0;
            r2_reg[0].z <= {2'b00, phi_b};
        end
    end

    // two rotation CORDICs for sin(60 - phi) and sin(phi)
    for (genvar s = 1; s <= N; s++)
    begin : g_sin
        localparam int unsigned I = s - 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_reg[s]  <= u_reg[s-1];
                k_reg[s]  <= k_reg[s-1];
                r1_reg[s] <= rot_step(r1_reg[s-1], I, svpd_pkg::ATAN_TURN[I]);
                r2_reg[s] <= rot_step(r2_reg[s-1], I, svpd_pkg::ATAN_TURN[I]);
            end
        end
    end

    // stage C: sqrt3 * sin
    always_comb
    begin
        p1 = 62'(svpd_pkg::SQRT3_Q30) * 62'(clamp_sin(r1_reg[N].y));
        p2 = 62'(svpd_pkg::SQRT3_Q30) * 62'(clamp_sin(r2_reg[N].y));
    end

    // stage D: scale by the modulation index
    always_comb
    begin
        m1 = $signed({1'b0, s1c_reg}) * uc_reg;
        m2 = $signed({1'b0, s2c_reg}) * uc_reg;
    end

    // stage E: seven-segment duties
    always_comb
    begin
        t1e = 22'(t1d_reg);
        t2e = 22'(t2d_reg);
        he  = (22'sd65536 - t1e - t2e) >>> 1;
        case (kd_reg)
            svpd_pkg::SECTOR_0:
            begin
                da_next = t1e + t2e + he;
                db_next = t2e + he;
                dc_next = he;
            end
            svpd_pkg::SECTOR_1:
            begin
                da_next = t1e + he;
                db_next = t1e + t2e + he;
                dc_next = he;
            end
            svpd_pkg::SECTOR_2:
            begin
                da_next = he;
                db_next = t1e + t2e + he;
                dc_next = t2e + he;
            end
            svpd_pkg::SECTOR_3:
            begin
                da_next = he;
                db_next = t1e + he;
                dc_next = t1e + t2e + he;
            end
            svpd_pkg::SECTOR_4:
            begin
                da_next = t2e + he;
                db_next = he;
                dc_next = t1e + t2e + he;
            end
            default:
            begin
                da_next = t1e + t2e + he;
                db_next = he;
                dc_next = t1e + he;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= vld_reg[N];
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uc_reg   <= u_reg[N];
            kc_reg   <= k_reg[N];
            s1c_reg  <= p1[60:30];
            s2c_reg  <= p2[60:30];
            kd_reg   <= kc_reg;
            t1d_reg  <= m1[49:30];
            t2d_reg  <= m2[49:30];
            ke_reg   <= kd_reg;
            da_reg   <= da_next;
            db_reg   <= db_next;
            dc_reg   <= dc_next;
            ca_reg   <= to_compare(da_reg, period);
            cb_reg   <= to_compare(db_reg, period);
            cc_reg   <= to_compare(dc_reg, period);
            sect_reg <= ke_reg + 3'd1;
        end
    end

    assign pwm.valid         = vf_reg;
    assign pwm.compare_a     = ca_reg;
    assign pwm.compare_b     = cb_reg;
    assign pwm.compare_c     = cc_reg;
    assign pwm.sector_number = sect_reg;

endmodule

`default_nettype wire

// ===== rtl/core/svpwm_phase_duty.sv =====
// Space vector PWM duty generator, seven-segment, centred compares.
// Channel vec takes a request (q_voltage, d_voltage in Q7.8, elec_angle as a
// 16-bit turn fraction); channel pwm returns compare_a/b/c and sector_number.
// Both are valid/ready; a transfer happens when valid and ready are high.
// A new request is taken every cycle while the queue is not full. From the vec
// transfer to pwm valid a request passes the square-root and vectoring CORDIC
// chain, then the two sine CORDICs and four multiply/duty stages.
// A front register and a two-entry queue sit ahead of the back pipeline.
// When pwm.valid is high and pwm.ready low the back pipeline holds in place;
// the front keeps taking requests until the queue fills, then drops vec.ready.
// Registers on the APB port: 0x0 timer period, 0x4 inv_supply_gain,
// 0x8 modulation_limit; write them only while no request is in flight.
// Reset empties the pipeline and queue and loads 1600, 5851 and 37814.
`default_nettype none

module svpwm_phase_duty #(
    parameter int ANGLE_BITS    = svpd_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = svpd_pkg::CORDIC_STAGES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    svpd_in_if.sink     vec,
    svpd_out_if.source  pwm,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] period_reg;
    logic [15:0] gain_reg;
    logic [15:0] limit_reg;

    logic                  push;
    logic                  pop;
    logic                  en;
    svpd_pkg::front_item_t front_item;
    svpd_pkg::front_item_t q_item;
    svpd_pkg::q_status_t   q_st;
    logic                  polar_valid;
    svpd_pkg::polar_item_t polar_item;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= svpd_pkg::PERIOD_RST;
            gain_reg   <= svpd_pkg::GAIN_RST;
            limit_reg  <= svpd_pkg::LIMIT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                svpd_pkg::REG_PERIOD: period_reg <= pwdata[15:0];
                svpd_pkg::REG_GAIN:   gain_reg   <= pwdata[15:0];
                svpd_pkg::REG_LIMIT:  limit_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            svpd_pkg::REG_PERIOD: prdata = {16'd0, period_reg};
            svpd_pkg::REG_GAIN:   prdata = {16'd0, gain_reg};
            svpd_pkg::REG_LIMIT:  prdata = {16'd0, limit_reg};
            default:              prdata = 32'd0;
        endcase
    end

    svpd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .vec    (vec),
        .q_full (q_st.full),
        .push   (push),
        .item   (front_item)
    );

    assign pop = en && !q_st.empty;

    svpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (front_item),
        .pop      (pop),
        .out_item (q_item),
        .status   (q_st)
    );

    svpd_polar #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (!q_st.empty),
        .in_item   (q_item),
        .gain      (gain_reg),
        .out_valid (polar_valid),
        .out_item  (polar_item)
    );

    svpd_duty #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_duty (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (polar_valid),
        .in_item  (polar_item),
        .period   (period_reg),
        .limit    (limit_reg),
        .en       (en),
        .pwm      (pwm)
    );

`ifndef SYNTHESIS
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        pwm.valid |-> (pwm.sector_number >= 3'd1 && pwm.sector_number <= 3'd6))
        else $error("sector number out of range");

    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vec.ready |-> q_st.full)
        else $error("front stalled with room in the queue");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (q_st.empty && !push) |=> q_st.empty)
        else $error("queue filled without a transfer from the front");

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_st.full && q_st.empty))
        else $error("queue both full and empty");
`endif

endmodule

`default_nettype wire
